@@ rtl/box_non_max_suppression_macros.svh @@
// assertion shorthands for the box suppression block
`ifndef BOX_NON_MAX_SUPPRESSION_MACROS_SVH
`define BOX_NON_MAX_SUPPRESSION_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BNMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define BNMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bnms_pkg.sv @@
`timescale 1ns / 1ps

package bnms_pkg;

  // sizes
  localparam int MAX_BOXES_DEF = 64;
  localparam int COORD_W       = 16;
  localparam int SCORE_W       = 16;
  localparam int BATCH_W       = 16;
  localparam int CLASS_W       = 10;
  localparam int BOX_W         = 6;
  localparam int SEL_W         = 7;
  localparam int RESULT_CAP    = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int BOX_WORD_W    = 4 * COORD_W;
  // candidate entry: {suppressed or taken mark, score, box}
  localparam int CAND_W        = 1 + SCORE_W + BOX_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SELECT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_FLOOR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_FORMAT = 2'd3;

  // register reset values
  localparam logic [SEL_W-1:0]   MAX_SELECT_RST = 7'd64;
  localparam logic [SCORE_W-1:0] IOU_LIMIT_RST  = 16'd32768;

  // item operations
  localparam logic OP_BOX   = 1'b0;
  localparam logic OP_SCORE = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [BATCH_W-1:0]        batch_id;
    logic [CLASS_W-1:0]        class_id;
    logic [BOX_W-1:0]          box_id;
    logic signed [COORD_W-1:0] coord_a;
    logic signed [COORD_W-1:0] coord_b;
    logic signed [COORD_W-1:0] coord_c;
    logic signed [COORD_W-1:0] coord_d;
    logic [SCORE_W-1:0]        score;
    logic                      last;
  } in_word_t;

  typedef struct packed {
    logic [BATCH_W-1:0] out_batch;
    logic [CLASS_W-1:0] out_class;
    logic [BOX_W-1:0]   out_box;
    logic               found;
    logic               run_end;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CAND,
    ST_WAIT_CAND,
    ST_WAIT_BOX,
    ST_WAIT_IOU,
    ST_PICK,
    ST_LOAD_SEL,
    ST_FINISH
  } nms_state_e;

  // overlap unit request and response
  typedef struct packed {
    logic                  start;
    logic [BOX_WORD_W-1:0] sel_box;
    logic [BOX_WORD_W-1:0] cand_box;
  } iou_req_t;

  typedef struct packed {
    logic done;
    logic suppress;
  } iou_rsp_t;

endpackage

@@ rtl/bnms_in_if.sv @@
`timescale 1ns / 1ps

interface bnms_in_if;
  logic               valid;
  logic               ready;
  bnms_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/bnms_out_if.sv @@
`timescale 1ns / 1ps

interface bnms_out_if;
  logic                valid;
  logic                ready;
  bnms_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/box_non_max_suppression.sv @@
`timescale 1ns / 1ps
// Greedy non-maximum suppression over up to MAX_BOXES boxes. Box words and
// score words that do not end a run are taken one per cycle. The score word
// with last set starts the run and in_if.ready stays low until its final
// result word has been loaded into the output register. The run makes one
// pass over the candidate memory to find the best candidate, then one pass
// per selection. A pass after a selection reads every candidate from the
// candidate memory; a live candidate also goes through a box memory read and
// the five-stage overlap unit, one candidate in flight at a time. A
// selection can wait for the previous result word to be taken. Suppression
// marks live in the candidate memory and are cleared by the fill of the next
// run, so no clearing pass after reset is needed.
`include "box_non_max_suppression_macros.svh"

module box_non_max_suppression #(
  parameter int MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bnms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bnms_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bnms_in_if.sink                         in_if,
  bnms_out_if.source                      out_if
);

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int SelW  = bnms_pkg::SEL_W;
  localparam int SW    = bnms_pkg::SCORE_W;
  localparam int BW    = bnms_pkg::BOX_W;
  localparam int BWW   = bnms_pkg::BOX_WORD_W;
  localparam int CDW   = bnms_pkg::CAND_W;

  bnms_pkg::nms_state_e state_q, state_d;

  // configuration
  logic [SelW-1:0] max_sel_q;
  logic [SW-1:0]   limit_q, floor_q;
  logic            cf_q;

  // run state
  logic [CNT_W-1:0]      cnt_q, k_q;
  logic [bnms_pkg::BATCH_W-1:0] batch_q;
  logic [bnms_pkg::CLASS_W-1:0] class_q;
  logic                  best_valid_q;
  logic [IDX_W-1:0]      best_k_q;
  logic [SW-1:0]         best_score_q, cur_score_q;
  logic [BW-1:0]         best_box_q, cur_box_q, pend_box_q;
  logic [BWW-1:0]        sel_box_q;
  logic                  have_sel_q, pend_valid_q;
  logic [SelW-1:0]       sel_cnt_q;
  logic                  out_valid_q;
  bnms_pkg::out_word_t   out_q;

  // memories
  logic                      box_we, cand_we;
  logic [IDX_W-1:0]          box_addr, cand_addr;
  logic [BWW-1:0]            box_rd;
  logic [CDW-1:0]            cand_rd, cand_wdata;
  logic                      rd_mark;
  logic [SW-1:0]             rd_score;
  logic [BW-1:0]             rd_box;

  bnms_pkg::iou_req_t iou_req;
  bnms_pkg::iou_rsp_t iou_rsp;

  // handshake and decode
  logic            in_fire, idx_ok, cand_ok, can_push, run_done;
  logic [SelW-1:0] limit;
  logic [IDX_W-1:0] k_idx;
  logic            k_end;
  logic            pick_go, push, step_next, consider, mark_sup, better;
  logic [SW-1:0]   cmp_score;
  logic [BW-1:0]   cmp_box;
  bnms_pkg::out_word_t push_word;

  assign in_fire  = in_if.valid && in_if.ready;
  assign idx_ok   = 32'(in_if.data.box_id) < 32'(MAX_BOXES);
  assign cand_ok  = idx_ok && (in_if.data.score >= floor_q) && (cnt_q < CNT_W'(MAX_BOXES));
  assign limit    = (max_sel_q > SelW'(bnms_pkg::RESULT_CAP)) ?
                    SelW'(bnms_pkg::RESULT_CAP) : max_sel_q;
  assign can_push = !out_valid_q || out_if.ready;
  assign run_done = (state_q == bnms_pkg::ST_FINISH) && can_push;
  assign k_idx    = k_q[IDX_W-1:0];
  assign k_end    = k_q >= cnt_q;
  assign rd_mark  = cand_rd[CDW-1];
  assign rd_score = cand_rd[CDW-2:BW];
  assign rd_box   = cand_rd[BW-1:0];

  assign in_if.ready  = (state_q == bnms_pkg::ST_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bnms_pkg::ST_IDLE: begin
        if (in_fire && in_if.data.op == bnms_pkg::OP_SCORE && in_if.data.last) begin
          state_d = bnms_pkg::ST_RD_CAND;
        end
      end
      bnms_pkg::ST_RD_CAND: begin
        state_d = k_end ? bnms_pkg::ST_PICK : bnms_pkg::ST_WAIT_CAND;
      end
      bnms_pkg::ST_WAIT_CAND: begin
        if (!rd_mark && have_sel_q) begin
          state_d = bnms_pkg::ST_WAIT_BOX;
        end else begin
          state_d = bnms_pkg::ST_RD_CAND;
        end
      end
      bnms_pkg::ST_WAIT_BOX: state_d = bnms_pkg::ST_WAIT_IOU;
      bnms_pkg::ST_WAIT_IOU: begin
        if (iou_rsp.done) begin
          state_d = bnms_pkg::ST_RD_CAND;
        end
      end
      bnms_pkg::ST_PICK: begin
        if (!(best_valid_q && sel_cnt_q < limit)) begin
          state_d = bnms_pkg::ST_FINISH;
        end else if (!pend_valid_q || can_push) begin
          state_d = bnms_pkg::ST_LOAD_SEL;
        end
      end
      bnms_pkg::ST_LOAD_SEL: state_d = bnms_pkg::ST_RD_CAND;
      bnms_pkg::ST_FINISH: begin
        if (can_push) begin
          state_d = bnms_pkg::ST_IDLE;
        end
      end
      default: state_d = bnms_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    box_we     = 1'b0;
    cand_we    = 1'b0;
    box_addr   = IDX_W'(best_box_q);
    cand_addr  = k_idx;
    cand_wdata = {1'b1, cur_score_q, cur_box_q};
    pick_go    = 1'b0;
    push       = 1'b0;
    step_next  = 1'b0;
    consider   = 1'b0;
    mark_sup   = 1'b0;
    cmp_score  = cur_score_q;
    cmp_box    = cur_box_q;
    push_word  = '{out_batch: batch_q, out_class: class_q, out_box: pend_box_q,
                   found: 1'b1, run_end: 1'b0};
    iou_req    = '{start: 1'b0, sel_box: sel_box_q, cand_box: box_rd};
    case (state_q)
      bnms_pkg::ST_IDLE: begin
        box_addr   = IDX_W'(in_if.data.box_id);
        cand_addr  = cnt_q[IDX_W-1:0];
        cand_wdata = {1'b0, in_if.data.score, in_if.data.box_id};
        box_we     = in_fire && in_if.data.op == bnms_pkg::OP_BOX && idx_ok;
        cand_we    = in_fire && in_if.data.op == bnms_pkg::OP_SCORE && cand_ok;
      end
      bnms_pkg::ST_WAIT_CAND: begin
        box_addr  = IDX_W'(rd_box);
        cmp_score = rd_score;
        cmp_box   = rd_box;
        consider  = !rd_mark && !have_sel_q;
        step_next = rd_mark || !have_sel_q;
      end
      bnms_pkg::ST_WAIT_BOX: begin
        iou_req.start = 1'b1;
      end
      bnms_pkg::ST_WAIT_IOU: begin
        step_next = iou_rsp.done;
        consider  = iou_rsp.done && !iou_rsp.suppress;
        mark_sup  = iou_rsp.done && iou_rsp.suppress;
        cand_we   = mark_sup;
      end
      bnms_pkg::ST_PICK: begin
        pick_go    = best_valid_q && sel_cnt_q < limit && (!pend_valid_q || can_push);
        push       = pick_go && pend_valid_q;
        cand_addr  = best_k_q;
        cand_wdata = {1'b1, best_score_q, best_box_q};
        cand_we    = pick_go;
      end
      bnms_pkg::ST_FINISH: begin
        push = can_push;
        push_word.run_end = 1'b1;
        if (!pend_valid_q) begin
          push_word.out_box = '0;
          push_word.found   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // candidate ordering: higher score, then lower box, then earlier slot
  assign better = !best_valid_q || (cmp_score > best_score_q) ||
                  (cmp_score == best_score_q && cmp_box < best_box_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bnms_pkg::ST_IDLE;
      max_sel_q    <= bnms_pkg::MAX_SELECT_RST;
      limit_q      <= bnms_pkg::IOU_LIMIT_RST;
      floor_q      <= '0;
      cf_q         <= 1'b0;
      cnt_q        <= '0;
      k_q          <= '0;
      best_valid_q <= 1'b0;
      have_sel_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      sel_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bnms_pkg::CFG_MAX_SELECT:    max_sel_q <= cfg_data_i[SelW-1:0];
          bnms_pkg::CFG_IOU_LIMIT:     limit_q   <= cfg_data_i[SW-1:0];
          bnms_pkg::CFG_SCORE_FLOOR:   floor_q   <= cfg_data_i[SW-1:0];
          bnms_pkg::CFG_CENTER_FORMAT: cf_q      <= cfg_data_i[0];
          default: ;
        endcase
      end
      // candidate fill and run start
      if (state_q == bnms_pkg::ST_IDLE && cand_we) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (state_q == bnms_pkg::ST_IDLE && state_d == bnms_pkg::ST_RD_CAND) begin
        k_q          <= '0;
        best_valid_q <= 1'b0;
        have_sel_q   <= 1'b0;
        pend_valid_q <= 1'b0;
        sel_cnt_q    <= '0;
      end
      if (step_next) begin
        k_q <= k_q + CNT_W'(1);
      end
      if (consider && better) begin
        best_valid_q <= 1'b1;
      end
      // take the best candidate as a selection
      if (pick_go) begin
        sel_cnt_q    <= sel_cnt_q + SelW'(1);
        pend_valid_q <= 1'b1;
        best_valid_q <= 1'b0;
        k_q          <= '0;
      end
      if (state_q == bnms_pkg::ST_LOAD_SEL) begin
        have_sel_q <= 1'b1;
      end
      // end of run empties the candidate list
      if (run_done) begin
        cnt_q <= '0;
      end
      // output word register
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && in_if.data.op == bnms_pkg::OP_SCORE && in_if.data.last) begin
      batch_q <= in_if.data.batch_id;
      class_q <= in_if.data.class_id;
    end
    if (state_q == bnms_pkg::ST_WAIT_CAND) begin
      cur_score_q <= rd_score;
      cur_box_q   <= rd_box;
    end
    if (consider && better) begin
      best_k_q     <= k_idx;
      best_score_q <= cmp_score;
      best_box_q   <= cmp_box;
    end
    if (pick_go) begin
      pend_box_q <= best_box_q;
    end
    if (state_q == bnms_pkg::ST_LOAD_SEL) begin
      sel_box_q <= box_rd;
    end
    if (push) begin
      out_q <= push_word;
    end
  end

  // raw box store, {d, c, b, a}
  bnms_ram #(
    .Width (BWW),
    .Depth (MAX_BOXES)
  ) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .addr_i  (box_addr),
    .wdata_i ({in_if.data.coord_d, in_if.data.coord_c,
               in_if.data.coord_b, in_if.data.coord_a}),
    .rdata_o (box_rd)
  );

  // candidate list, {mark, score, box}
  bnms_ram #(
    .Width (CDW),
    .Depth (MAX_BOXES)
  ) u_cand_ram (
    .clk_i   (clk_i),
    .we_i    (cand_we),
    .addr_i  (cand_addr),
    .wdata_i (cand_wdata),
    .rdata_o (cand_rd)
  );

  // overlap test against the current selection
  bnms_iou u_iou (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .center_format_i (cf_q),
    .iou_limit_i     (limit_q),
    .req_i           (iou_req),
    .rsp_o           (iou_rsp)
  );

  // checks
  `BNMS_ASSERT_NOW(a_iou_in_wait, iou_rsp.done, state_q == bnms_pkg::ST_WAIT_IOU, "stray iou")
  `BNMS_ASSERT_NOW(a_sel_within_limit, pick_go, sel_cnt_q < limit, "selection beyond limit")
  `BNMS_ASSERT_NEXT(a_run_clears, run_done, cnt_q == '0, "run end left candidates")

endmodule

@@ rtl/bnms_ram.sv @@
`timescale 1ns / 1ps

module bnms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bnms_iou.sv @@
`timescale 1ns / 1ps

module bnms_iou (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         center_format_i,
  input  logic [bnms_pkg::SCORE_W-1:0] iou_limit_i,
  input  bnms_pkg::iou_req_t           req_i,
  output bnms_pkg::iou_rsp_t           rsp_o
);

  localparam int CW = bnms_pkg::COORD_W;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int UW = PW + 2;
  localparam int LW = bnms_pkg::SCORE_W;
  localparam int QW = UW + LW + 1;
  localparam int FRAC = 16;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [DW-1:0] v);
    logic signed [CW-1:0] r;
    if (v[DW-1] != v[DW-2]) begin
      r = v[DW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // corners packed as {x2, y2, x1, y1}
  function automatic logic [4*CW-1:0] to_corners(input logic [4*CW-1:0] raw, input logic cf);
    logic signed [CW-1:0] a, b, w, h, hw, hh;
    logic [4*CW-1:0] r;
    a  = raw[CW-1:0];
    b  = raw[2*CW-1:CW];
    w  = raw[3*CW-1:2*CW];
    h  = raw[4*CW-1:3*CW];
    hw = w >>> 1;
    hh = h >>> 1;
    if (cf) begin
      r = {sat_coord(DW'(a) + DW'(hw)), sat_coord(DW'(b) + DW'(hh)),
           sat_coord(DW'(a) - DW'(hw)), sat_coord(DW'(b) - DW'(hh))};
    end else begin
      r = raw;
    end
    return r;
  endfunction

  logic [4:0] v_q;
  logic [4*CW-1:0] p_q, q_q;
  logic signed [DW-1:0] ih_q, iw_q, dhp_q, dwp_q, dhq_q, dwq_q;
  logic signed [PW-1:0] inter3_q, a1_q, a2_q, inter4_q;
  logic signed [UW-1:0] uni_q;
  logic signed [PW+FRAC-1:0] lhs_q;
  logic signed [QW-1:0] prod_q;
  logic pos_q;

  logic signed [CW-1:0] py1, px1, py2, px2, qy1, qx1, qy2, qx2;
  logic signed [CW-1:0] iy1, ix1, iy2, ix2;
  logic signed [DW-1:0] ih, iw;

  // corner fields and intersection extents
  always_comb begin
    py1 = p_q[CW-1:0];
    px1 = p_q[2*CW-1:CW];
    py2 = p_q[3*CW-1:2*CW];
    px2 = p_q[4*CW-1:3*CW];
    qy1 = q_q[CW-1:0];
    qx1 = q_q[2*CW-1:CW];
    qy2 = q_q[3*CW-1:2*CW];
    qx2 = q_q[4*CW-1:3*CW];
    iy1 = (py1 > qy1) ? py1 : qy1;
    ix1 = (px1 > qx1) ? px1 : qx1;
    iy2 = (py2 < qy2) ? py2 : qy2;
    ix2 = (px2 < qx2) ? px2 : qx2;
    ih  = DW'(iy2) - DW'(iy1);
    iw  = DW'(ix2) - DW'(ix1);
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], req_i.start};
    end
  end

  // arithmetic stages
  always_ff @(posedge clk_i) begin
    p_q      <= to_corners(req_i.sel_box, center_format_i);
    q_q      <= to_corners(req_i.cand_box, center_format_i);
    ih_q     <= ih[DW-1] ? '0 : ih;
    iw_q     <= iw[DW-1] ? '0 : iw;
    dhp_q    <= DW'(py2) - DW'(py1);
    dwp_q    <= DW'(px2) - DW'(px1);
    dhq_q    <= DW'(qy2) - DW'(qy1);
    dwq_q    <= DW'(qx2) - DW'(qx1);
    inter3_q <= ih_q * iw_q;
    a1_q     <= dwp_q * dhp_q;
    a2_q     <= dwq_q * dhq_q;
    uni_q    <= UW'(a1_q) + UW'(a2_q) - UW'(inter3_q);
    inter4_q <= inter3_q;
    pos_q    <= uni_q > 0;
    prod_q   <= $signed({1'b0, iou_limit_i}) * uni_q;
    lhs_q    <= {inter4_q, {FRAC{1'b0}}};
  end

  assign rsp_o.done     = v_q[4];
  assign rsp_o.suppress = pos_q && (QW'(lhs_q) > prod_q);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// predicts the selection words of the suppression block and checks them
class nms_scoreboard;
  logic [4*bnms_pkg::COORD_W-1:0] boxes [bnms_pkg::MAX_BOXES_DEF];
  int unsigned cand_score [bnms_pkg::MAX_BOXES_DEF];
  int unsigned cand_box [bnms_pkg::MAX_BOXES_DEF];
  int cand_cnt;
  int unsigned max_select = 64;
  int unsigned iou_limit = 32768;
  int unsigned score_floor = 0;
  bit center_fmt = 1'b0;
  bnms_pkg::out_word_t pending [$];
  int errors;

  function void set_reg(logic [bnms_pkg::CFG_IDX_W-1:0] idx,
                        logic [bnms_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      bnms_pkg::CFG_MAX_SELECT: max_select = v[bnms_pkg::SEL_W-1:0];
      bnms_pkg::CFG_IOU_LIMIT: iou_limit = v;
      bnms_pkg::CFG_SCORE_FLOOR: score_floor = v;
      bnms_pkg::CFG_CENTER_FORMAT: center_fmt = v[0];
      default: ;
    endcase
  endfunction

  function int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // box word to y1, x1, y2, x2
  function void corners(int unsigned idx, output int y1, output int x1,
                        output int y2, output int x2);
    logic signed [bnms_pkg::COORD_W-1:0] a, b, c, d;
    int hw, hh;
    {a, b, c, d} = boxes[idx];
    if (center_fmt) begin
      hw = int'(c) >>> 1;
      hh = int'(d) >>> 1;
      y1 = sat16(int'(b) - hh);
      x1 = sat16(int'(a) - hw);
      y2 = sat16(int'(b) + hh);
      x2 = sat16(int'(a) + hw);
    end else begin
      y1 = a; x1 = b; y2 = c; x2 = d;
    end
  endfunction

  function bit too_close(int unsigned i, int unsigned j);
    int py1, px1, py2, px2, qy1, qx1, qy2, qx2;
    longint ih, iw, inter, a1, a2, uni;
    corners(i, py1, px1, py2, px2);
    corners(j, qy1, qx1, qy2, qx2);
    ih = longint'(py2 < qy2 ? py2 : qy2) - longint'(py1 > qy1 ? py1 : qy1);
    iw = longint'(px2 < qx2 ? px2 : qx2) - longint'(px1 > qx1 ? px1 : qx1);
    if (ih < 0) ih = 0;
    if (iw < 0) iw = 0;
    inter = ih * iw;
    a1 = longint'(px2 - px1) * longint'(py2 - py1);
    a2 = longint'(qx2 - qx1) * longint'(qy2 - qy1);
    uni = a1 + a2 - inter;
    if (uni <= 0) return 1'b0;
    return inter * 65536 > longint'(iou_limit) * uni;
  endfunction

  function void note_input(bnms_pkg::in_word_t w);
    int unsigned s, b, lim, sel;
    int j;
    bit sup [bnms_pkg::MAX_BOXES_DEF];
    bnms_pkg::out_word_t r;
    if (w.op == bnms_pkg::OP_BOX) begin
      boxes[w.box_id] = {w.coord_a, w.coord_b, w.coord_c, w.coord_d};
      return;
    end
    if (w.score >= score_floor && cand_cnt < bnms_pkg::MAX_BOXES_DEF) begin
      cand_score[cand_cnt] = w.score;
      cand_box[cand_cnt] = w.box_id;
      cand_cnt++;
    end
    if (!w.last) return;
    // stable order: higher score first, then lower box index
    for (int i = 1; i < cand_cnt; i++) begin
      s = cand_score[i]; b = cand_box[i]; j = i;
      while (j > 0 && (s > cand_score[j-1] || (s == cand_score[j-1] && b < cand_box[j-1])))
      begin
        cand_score[j] = cand_score[j-1];
        cand_box[j] = cand_box[j-1];
        j--;
      end
      cand_score[j] = s; cand_box[j] = b;
    end
    lim = max_select > bnms_pkg::RESULT_CAP ? bnms_pkg::RESULT_CAP : max_select;
    sel = 0;
    foreach (sup[k]) sup[k] = 1'b0;
    // greedy pick with suppression of later candidates
    for (int i = 0; i < cand_cnt && sel < lim; i++) begin
      if (sup[i]) continue;
      r.out_batch = w.batch_id;
      r.out_class = w.class_id;
      r.out_box = bnms_pkg::BOX_W'(cand_box[i]);
      r.found = 1'b1;
      r.run_end = 1'b0;
      pending = {pending, r};
      sel++;
      for (int k = i + 1; k < cand_cnt; k++)
        if (!sup[k] && too_close(cand_box[i], cand_box[k])) sup[k] = 1'b1;
    end
    if (sel == 0) begin
      r.out_batch = w.batch_id;
      r.out_class = w.class_id;
      r.out_box = '0;
      r.found = 1'b0;
      r.run_end = 1'b1;
      pending = {pending, r};
    end else begin
      pending[$].run_end = 1'b1;
    end
    cand_cnt = 0;
  endfunction

  function void check_result(bnms_pkg::out_word_t r);
    bnms_pkg::out_word_t e;
    if (pending.size() == 0) begin
      errors++;
      $error("unexpected result word: box %0d found %0b", r.out_box, r.found);
      return;
    end
    e = pending.pop_front();
    if (r.out_batch !== e.out_batch) begin
      errors++;
      $error("out_batch mismatch: expected %0d, actual %0d", e.out_batch, r.out_batch);
    end
    if (r.out_class !== e.out_class) begin
      errors++;
      $error("out_class mismatch: expected %0d, actual %0d", e.out_class, r.out_class);
    end
    if (r.out_box !== e.out_box) begin
      errors++;
      $error("out_box mismatch: expected %0d, actual %0d", e.out_box, r.out_box);
    end
    if (r.found !== e.found) begin
      errors++;
      $error("found mismatch: expected %0d, actual %0d", e.found, r.found);
    end
    if (r.run_end !== e.run_end) begin
      errors++;
      $error("run_end mismatch: expected %0d, actual %0d", e.run_end, r.run_end);
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int CW = bnms_pkg::COORD_W;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bnms_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [bnms_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  bnms_in_if in_if ();
  bnms_out_if out_if ();

  nms_scoreboard sb = new();
  int cycles;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;
  logic [bnms_pkg::MAX_BOXES_DEF-1:0] loaded;

  box_non_max_suppression u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // result side: check accepted words, random stalls, long hold-off
  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // send one word, with a random gap before it
  task automatic send_word(bnms_pkg::in_word_t w);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(w);
    items_sent++;
  endtask

  function automatic logic [CW-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CW'($urandom_range(0, 600) - 300);
    if (r < 85) return CW'($urandom);
    return r[0] ? 16'h7fff : 16'h8000;
  endfunction

  task automatic send_box(int unsigned idx, logic [CW-1:0] a, logic [CW-1:0] b,
                          logic [CW-1:0] c, logic [CW-1:0] d);
    bnms_pkg::in_word_t w;
    w.op = bnms_pkg::OP_BOX;
    w.batch_id = bnms_pkg::BATCH_W'($urandom);
    w.class_id = bnms_pkg::CLASS_W'($urandom);
    w.box_id = bnms_pkg::BOX_W'(idx);
    w.coord_a = a; w.coord_b = b; w.coord_c = c; w.coord_d = d;
    w.score = bnms_pkg::SCORE_W'($urandom);
    w.last = 1'($urandom);
    send_word(w);
    loaded[idx] = 1'b1;
  endtask

  task automatic send_rand_box(int unsigned idx);
    logic [CW-1:0] a, b;
    a = rand_coord();
    b = rand_coord();
    if (sb.center_fmt)
      send_box(idx, a, b, CW'($urandom_range(0, 220) - 10),
               CW'($urandom_range(0, 220) - 10));
    else
      send_box(idx, a, b, a + CW'($urandom_range(0, 220) - 20),
               b + CW'($urandom_range(0, 220) - 20));
  endtask

  task automatic send_score(logic [bnms_pkg::BATCH_W-1:0] bt,
                            logic [bnms_pkg::CLASS_W-1:0] cl, int unsigned idx,
                            logic [bnms_pkg::SCORE_W-1:0] s, logic lst);
    bnms_pkg::in_word_t w;
    w.op = bnms_pkg::OP_SCORE;
    w.batch_id = bt;
    w.class_id = cl;
    w.box_id = bnms_pkg::BOX_W'(idx);
    w.coord_a = CW'($urandom); w.coord_b = CW'($urandom);
    w.coord_c = CW'($urandom); w.coord_d = CW'($urandom);
    w.score = s;
    w.last = lst;
    send_word(w);
  endtask

  // one run: n_load box loads, then scores on loaded boxes (now and then with an extra box load), ending in last
  task automatic rand_run(int n_load, int n_score);
    logic [bnms_pkg::BATCH_W-1:0] bt;
    logic [bnms_pkg::CLASS_W-1:0] cl;
    int unsigned idx;
    logic [bnms_pkg::SCORE_W-1:0] s;
    bt = bnms_pkg::BATCH_W'($urandom);
    cl = bnms_pkg::CLASS_W'($urandom);
    for (int k = 0; k < n_load; k++) send_rand_box($urandom_range(0, 63));
    for (int k = 0; k < n_score; k++) begin
      do idx = $urandom_range(0, 63); while (!loaded[idx]);
      if ($urandom_range(0, 3) == 0) s = bnms_pkg::SCORE_W'($urandom_range(0, 3) * 16384);
      else s = bnms_pkg::SCORE_W'($urandom);
      if ($urandom_range(0, 15) == 0) send_rand_box($urandom_range(0, 63));
      send_score(bt, cl, idx, s, k == n_score - 1);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bnms_pkg::CFG_IDX_W-1:0] idx,
                           logic [bnms_pkg::CFG_DATA_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic set_regs(int unsigned ms, int unsigned iou, int unsigned fl, bit cf);
    write_reg(bnms_pkg::CFG_MAX_SELECT, bnms_pkg::CFG_DATA_W'(ms));
    write_reg(bnms_pkg::CFG_IOU_LIMIT, bnms_pkg::CFG_DATA_W'(iou));
    write_reg(bnms_pkg::CFG_SCORE_FLOOR, bnms_pkg::CFG_DATA_W'(fl));
    write_reg(bnms_pkg::CFG_CENTER_FORMAT, bnms_pkg::CFG_DATA_W'(cf));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    loaded = '0;
    send_idle_pct = 19;
    recv_idle_pct = 78;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, ties, repeated box, negative-size box
    send_box(0, 16'd0, 16'd0, 16'd160, 16'd160);
    send_box(1, 16'd16, 16'd16, 16'd176, 16'd176);
    send_box(2, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_box(3, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_box(4, 16'd1000, 16'd1000, 16'd1100, 16'd1100);
    send_box(63, 16'd1010, 16'd1010, 16'd1090, 16'd1090);
    send_score(16'hffff, 10'h3ff, 0, 16'hffff, 1'b0);
    send_score(16'hffff, 10'h3ff, 1, 16'hffff, 1'b0);
    send_score(16'hffff, 10'h3ff, 2, 16'h0000, 1'b0);
    send_score(16'hffff, 10'h3ff, 3, 16'd30000, 1'b0);
    send_score(16'hffff, 10'h3ff, 63, 16'd30000, 1'b0);
    send_score(16'hffff, 10'h3ff, 4, 16'd30000, 1'b0);
    send_score(16'hffff, 10'h3ff, 1, 16'd100, 1'b1);
    send_score(16'h0000, 10'h000, 4, 16'd1, 1'b1);
    send_score(16'h5555, 10'h2aa, 63, 16'd7, 1'b0);
    send_score(16'h5555, 10'h2aa, 4, 16'd7, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph < 2) begin
        send_idle_pct = 19; recv_idle_pct = 78;
      end else if (ph < 4) begin
        send_idle_pct = 78; recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      case (ph)
        0: set_regs(5, 0, 0, 1'b0);
        1: set_regs(0, 65535, 65535, 1'b1);
        2: set_regs(127, 32768, 0, 1'b0);
        3: set_regs(3, 16384, 20000, 1'b1);
        4: set_regs($urandom_range(0, 127), $urandom_range(0, 65535),
                    $urandom_range(0, 40000), 1'($urandom_range(0, 1)));
        default: set_regs(64, 65535, 0, 1'b0);
      endcase
      // full candidate list: every box loaded, more scores than slots
      if (ph == 2) begin
        for (int k = 0; k < 64; k++) if (!loaded[k]) send_rand_box(k);
        rand_run(0, 70);
      end
      // block fills up while results are held off
      if (ph == 3) begin
        hold_req = 1'b1;
        rand_run(2, 3);
        rand_run(6, 2);
      end
      while (items_sent < 25 + 58 * (ph + 1)) begin
        if ($urandom_range(0, 19) == 0) rand_run($urandom_range(1, 4), $urandom_range(10, 30));
        else rand_run($urandom_range(0, 4), $urandom_range(1, 6));
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
